FILE: rtl/b64e_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types and constants for the base64 stream encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

	localparam logic [7:0] PAD_CHAR   = 8'h3D;
	localparam logic [7:0] PLUS_CHAR  = 8'h2B;
	localparam logic [7:0] SLASH_CHAR = 8'h2F;

	typedef struct packed {
		logic       pad;
		logic [5:0] idx;
	} sym_t;

	typedef struct packed {
		sym_t [3:0] syms;
		logic [1:0] cnt_m1;
		logic       last;
	} job_t;

	function automatic logic [7:0] sym_char(input logic [5:0] idx);
		logic [7:0] c;
		if (idx < 6'd26) begin
			c = 8'h41 + {2'b00, idx};
		end else if (idx < 6'd52) begin
			c = 8'h47 + {2'b00, idx};
		end else if (idx < 6'd62) begin
			c = {2'b00, idx} - 8'd4;
		end else if (idx == 6'd62) begin
			c = PLUS_CHAR;
		end else begin
			c = SLASH_CHAR;
		end
		return c;
	endfunction

	function automatic logic [7:0] out_char(input sym_t s);
		logic [7:0] c;
		if (s.pad) begin
			c = PAD_CHAR;
		end else begin
			c = sym_char(s.idx);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/b64e_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Accepts bytes, tracks the group phase and builds one character job per byte.
// ----------------------------------------------------------------------------
module b64e_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [7:0]    data_byte,
	input  wire logic          last_byte,
	input  wire logic          q_full,
	output logic               push,
	output b64e_pkg::job_t     job
);

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} phase_t;

	phase_t     phase_q;
	logic [3:0] carry_q;
	phase_t     phase_d;
	logic [3:0] carry_d;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	always_comb begin
		job        = '0;
		job.last   = last_byte;
		phase_d    = PH_FIRST;
		carry_d    = '0;
		unique case (phase_q)
			PH_SECOND: begin
				job.syms[0].idx = {carry_q[1:0], data_byte[7:4]};
				job.syms[1].idx = {data_byte[3:0], 2'b00};
				job.syms[2].pad = 1'b1;
				job.cnt_m1      = last_byte ? 2'd2 : 2'd0;
				phase_d         = PH_THIRD;
				carry_d         = data_byte[3:0];
			end
			PH_THIRD: begin
				job.syms[0].idx = {carry_q, data_byte[7:6]};
				job.syms[1].idx = data_byte[5:0];
				job.cnt_m1      = 2'd1;
			end
			default: begin
				job.syms[0].idx = data_byte[7:2];
				job.syms[1].idx = {data_byte[1:0], 4'b0000};
				job.syms[2].pad = 1'b1;
				job.syms[3].pad = 1'b1;
				job.cnt_m1      = last_byte ? 2'd3 : 2'd0;
				phase_d         = PH_SECOND;
				carry_d         = {2'b00, data_byte[1:0]};
			end
		endcase
		if (last_byte) begin
			phase_d = PH_FIRST;
			carry_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			carry_q <= carry_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/b64e_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module b64e_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire b64e_pkg::job_t wr_job,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output b64e_pkg::job_t     rd_job
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	b64e_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/b64e_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Walks the head job one character per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module b64e_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire b64e_pkg::job_t job,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [7:0]          out_char,
	output logic                end_of_text
);

	logic [1:0] sel_q;
	logic       out_valid_q;
	logic [7:0] out_char_q;
	logic       eot_q;
	logic       adv;
	logic       load;
	logic       at_end;

	assign adv         = !out_valid_q || out_ready;
	assign load        = adv && job_valid;
	assign at_end      = (sel_q == job.cnt_m1);
	assign pop         = load && at_end;
	assign out_valid   = out_valid_q;
	assign out_char    = out_char_q;
	assign end_of_text = eot_q;

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= b64e_pkg::out_char(job.syms[sel_q]);
			eot_q      <= job.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			sel_q       <= at_end ? 2'd0 : sel_q + 2'd1;
		end else if (adv) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/base64_stream_encoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_encoder_top
// Streaming base64 encoder: raw bytes in, alphabet and pad characters out.
// ----------------------------------------------------------------------------
//  channel   dir  tdata           tlast
//  s_axis    in   data_byte[7:0]  last_byte
//  m_axis    out  out_char[7:0]   end_of_text
//
// a byte is taken in one cycle whenever the job queue has room
// characters leave one per cycle while m_axis is not stalled, from a registered output, 1 to 4 per byte
// sustained rate is set by the output port: 4 characters per 3 bytes
// reset clears group phase, queue and output valid flag
// output stalls fill the queue, then drop s_axis_tready
// ----------------------------------------------------------------------------
module base64_stream_encoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // data_byte[7:0]
	input  wire logic       s_axis_tlast,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // out_char[7:0]
	output logic            m_axis_tlast
);

	b64e_pkg::job_t wr_job;
	b64e_pkg::job_t rd_job;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_not_empty;

	b64e_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.data_byte (s_axis_tdata),
		.last_byte (s_axis_tlast),
		.q_full    (q_full),
		.push      (push),
		.job       (wr_job)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (wr_job),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.rd_job    (rd_job)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (q_not_empty),
		.job         (rd_job),
		.pop         (pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_char    (m_axis_tdata),
		.end_of_text (m_axis_tlast)
	);

endmodule
`default_nettype wire

FILE: rtl/b64e_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_checker
// Port-level checks for the base64 stream encoder.
// ----------------------------------------------------------------------------
module b64e_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       s_axis_tlast,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast
);

	logic       in_xact;
	logic       in_last_xact;
	logic [7:0] ch;

	assign in_xact      = s_axis_tvalid && s_axis_tready;
	assign in_last_xact = in_xact && s_axis_tlast && (s_axis_tdata == s_axis_tdata);
	assign ch           = m_axis_tdata;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("output dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed while stalled");

	a_alphabet: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
			(ch >= 8'h30 && ch <= 8'h39) || ch == b64e_pkg::PLUS_CHAR ||
			ch == b64e_pkg::SLASH_CHAR || ch == b64e_pkg::PAD_CHAR)
		else $error("character outside base64 alphabet");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with idle output");

	// a job pushed into an empty queue is written to its memory before the back part loads it
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		in_last_xact && !m_axis_tvalid |-> ##[1:2] m_axis_tvalid)
		else $error("last byte produced no output");

endmodule

bind base64_stream_encoder_top b64e_checker u_b64e_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.s_axis_tlast  (s_axis_tlast),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the base64 stream encoder. A scoreboard tracks the
// group phase and carry bits, builds the expected characters for each byte
// taken in, and compares every character leaving the block, including the
// end-of-text flag. Directed messages ending at each group phase come first,
// then random messages with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_BYTES = 320;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int SETTLE_TIME  = 20;

	typedef enum logic [1:0] {
		PH_FIRST  = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD  = 2'd2
	} group_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} enc_char_t;

	class b64_scoreboard;
		string      alphabet;
		logic [1:0] phase;
		logic [3:0] carry;
		enc_char_t  expected_chars[$];
		int         mismatches;
		int         bytes_in;
		int         chars_out;
		int         messages;
		int         ends_at_phase[3];

		function new();
			alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
			phase = PH_FIRST;
			carry = 4'd0;
			mismatches = 0;
			bytes_in = 0;
			chars_out = 0;
			messages = 0;
			for (int i = 0; i < 3; i++) begin
				ends_at_phase[i] = 0;
			end
		endfunction

		function logic [7:0] symbol(input logic [5:0] v);
			return alphabet.getc(int'(v));
		endfunction

		function void note_byte(input logic [7:0] b, input logic last);
			logic [7:0] chars[4];
			int         n;
			n = 0;
			bytes_in++;
			case (phase)
				PH_SECOND: begin
					if (last) begin
						ends_at_phase[1]++;
					end
					chars[0] = symbol({carry[1:0], b[7:4]});
					n = 1;
					carry = b[3:0];
					phase = PH_THIRD;
					if (last) begin
						chars[1] = symbol({b[3:0], 2'b00});
						chars[2] = b64e_pkg::PAD_CHAR;
						n = 3;
					end
				end
				PH_THIRD: begin
					if (last) begin
						ends_at_phase[2]++;
					end
					chars[0] = symbol({carry, b[7:6]});
					chars[1] = symbol(b[5:0]);
					n = 2;
					carry = 4'd0;
					phase = PH_FIRST;
				end
				default: begin
					if (last) begin
						ends_at_phase[0]++;
					end
					chars[0] = symbol(b[7:2]);
					n = 1;
					carry = {2'b00, b[1:0]};
					phase = PH_SECOND;
					if (last) begin
						chars[1] = symbol({b[1:0], 4'b0000});
						chars[2] = b64e_pkg::PAD_CHAR;
						chars[3] = b64e_pkg::PAD_CHAR;
						n = 4;
					end
				end
			endcase
			for (int i = 0; i < n; i++) begin
				expected_chars.push_back('{ch: chars[i], eot: (last && i == n - 1)});
			end
			if (last) begin
				phase = PH_FIRST;
				carry = 4'd0;
				messages++;
			end
		endfunction

		task report_mismatch(input string msg);
			mismatches++;
			if (mismatches <= 40) begin
				$display("MISMATCH @%0t: %s", $time, msg);
			end
		endtask

		task check_char(input logic [7:0] ch, input logic eot);
			enc_char_t want;
			chars_out++;
			if (expected_chars.size() == 0) begin
				report_mismatch($sformatf("char %0d (0x%02h) with nothing expected",
					chars_out, ch));
			end else begin
				want = expected_chars.pop_front();
				if (ch !== want.ch) begin
					report_mismatch($sformatf("char %0d: got 0x%02h, want 0x%02h",
						chars_out, ch, want.ch));
				end
				if (eot !== want.eot) begin
					report_mismatch($sformatf("char %0d: tlast %0b, want %0b",
						chars_out, eot, want.eot));
				end
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic       s_axis_tlast = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic       m_axis_tlast;

	b64_scoreboard sb = new();
	logic [7:0]    msg_bytes[$];
	int            cycles = 0;

	base64_stream_encoder_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still pending", cycles,
				sb.expected_chars.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// transaction monitors
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			sb.note_byte(s_axis_tdata, s_axis_tlast);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			sb.check_char(m_axis_tdata, m_axis_tlast);
		end
	end

	// output side: random stalls, switching between busy and open stretches
	initial begin
		int  stall;
		bit  busy;
		busy = 1'b1;
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) begin
				busy = !busy;
			end
			stall = busy ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] d, input logic l, input int gap);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= d;
		s_axis_tlast  <= l;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// gap_mode 0 streams back to back, otherwise each byte waits a random gap before it is sent
	task automatic send_message(input int gap_mode);
		int gap;
		for (int i = 0; i < msg_bytes.size(); i++) begin
			gap = (gap_mode == 0) ? 0 : $urandom_range(0, 12);
			send_byte(msg_bytes[i], i == msg_bytes.size() - 1, gap);
		end
	endtask

	initial begin
		int sent;
		int len;
		int drain;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single bytes: extremes and the '+' symbol
		msg_bytes = '{8'h00};
		send_message(1);
		msg_bytes = '{8'hFF};
		send_message(0);
		msg_bytes = '{8'hF8};
		send_message(1);
		// two bytes, ending with one pad
		msg_bytes = '{8'hFF, 8'hFF};
		send_message(0);
		msg_bytes = '{8'h00, 8'h00};
		send_message(1);
		// full groups, no padding
		msg_bytes = '{8'hFF, 8'hFF, 8'hFF};
		send_message(1);
		msg_bytes = '{8'h00, 8'h00, 8'h00};
		send_message(0);
		msg_bytes = '{8'h4D, 8'h61, 8'h6E};
		send_message(1);
		// group wrap, then end after one and after two bytes of the next group
		msg_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF};
		send_message(0);
		msg_bytes = '{8'hFB, 8'hEF, 8'hBE, 8'hAA, 8'h55};
		send_message(1);

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
			msg_bytes.delete();
			for (int i = 0; i < len; i++) begin
				msg_bytes.push_back(8'($urandom_range(0, 255)));
			end
			send_message($urandom_range(0, 3));
			sent += len;
		end
		s_axis_tvalid <= 1'b0;

		drain = 0;
		while (sb.expected_chars.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE_TIME) @(posedge clk);
		if (sb.expected_chars.size() != 0) begin
			sb.report_mismatch($sformatf("%0d expected characters never arrived",
				sb.expected_chars.size()));
		end

		$display("encoded %0d messages from %0d bytes, %0d characters checked",
			sb.messages, sb.bytes_in, sb.chars_out);
		$display("messages ending after 1/2/3 bytes of a group: %0d/%0d/%0d",
			sb.ends_at_phase[0], sb.ends_at_phase[1], sb.ends_at_phase[2]);
		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
